>>> rtl/fexp_pkg.sv
`timescale 1ns / 1ps

package fexp_pkg;

   typedef logic [63:0] f64_type;

   localparam int TABLE_ENTRIES = 32;
   localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);
   localparam int SCALE_SHIFT   = 52 - INDEX_BITS;

   // stage counts of the arithmetic units
   localparam int MUL_LAT = 3;
   localparam int ADD_LAT = 4;
   localparam int NAR_LAT = 2;

   localparam logic [10:0] EXP_BIAS     = 11'd1023;
   // binary64 bias less binary32 bias
   localparam logic [10:0] EXP_REBIAS   = 11'd896;

   localparam logic [31:0] F32_LIMIT    = 32'h42b00000;
   localparam logic [31:0] F32_INF      = 32'h7f800000;
   localparam logic [31:0] F32_QUIET    = 32'h00400000;
   localparam logic [31:0] F32_POS_MAX  = 32'h42b17217;
   localparam logic [31:0] F32_NEG_MAX  = 32'h42cff1b4;
   localparam logic [31:0] F32_ZERO     = 32'h00000000;

   localparam f64_type C_LOG2E_32  = 64'h40471547652b82fe;
   localparam f64_type C_SHIFTER   = 64'h4338000000000000;
   localparam f64_type C_NSHIFTER  = 64'hc338000000000000;
   localparam f64_type C_POLY_A    = 64'h3ebc6af84b912394;
   localparam f64_type C_POLY_B    = 64'h3f2ebfce50fac4f3;
   localparam f64_type C_POLY_C    = 64'h3f962e42ff0c52d6;
   localparam f64_type C_ONE       = 64'h3ff0000000000000;

   // 2^(j/32) with j<<47 taken off the bits
   localparam f64_type EXP2_TBL [TABLE_ENTRIES] = '{
      64'h3ff0000000000000, 64'h3fefd9b0d3158574,
      64'h3fefb5586cf9890f, 64'h3fef9301d0125b51,
      64'h3fef72b83c7d517b, 64'h3fef54873168b9aa,
      64'h3fef387a6e756238, 64'h3fef1e9df51fdee1,
      64'h3fef06fe0a31b715, 64'h3feef1a7373aa9cb,
      64'h3feedea64c123422, 64'h3feece086061892d,
      64'h3feebfdad5362a27, 64'h3feeb42b569d4f82,
      64'h3feeab07dd485429, 64'h3feea47eb03a5585,
      64'h3feea09e667f3bcd, 64'h3fee9f75e8ec5f74,
      64'h3feea11473eb0187, 64'h3feea589994cce13,
      64'h3feeace5422aa0db, 64'h3feeb737b0cdc5e5,
      64'h3feec49182a3f090, 64'h3feed503b23e255d,
      64'h3feee89f995ad3ad, 64'h3feeff76f2fb5e47,
      64'h3fef199bdd85529c, 64'h3fef3720dcef9069,
      64'h3fef5818dcfba487, 64'h3fef7c97337b9b5f,
      64'h3fefa4afa2a490da, 64'h3fefd0765b6e4540
   };

endpackage

>>> rtl/fexp_dly.sv
`timescale 1ns / 1ps

module fexp_dly #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] tap_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            tap_ff[i] <= '0;
         end
      end else if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[N-1];

endmodule

>>> rtl/fexp_mul64.sv
`timescale 1ns / 1ps

module fexp_mul64 (
   input  logic              clock,
   input  logic              en,
   input  fexp_pkg::f64_type a,
   input  fexp_pkg::f64_type b,
   output fexp_pkg::f64_type y
);

   logic [52:0]  ma, mb;
   logic [51:0]  hh_in;
   logic [52:0]  hl_in, lh_in;
   logic [53:0]  ll_in;
   logic [12:0]  e_in;

   logic [51:0]  hh_ff;
   logic [52:0]  hl_ff, lh_ff;
   logic [53:0]  ll_ff;
   logic [12:0]  e_a_ff;
   logic         s_a_ff, z_a_ff;

   logic [105:0] mid, p_in;
   logic [105:0] p_ff;
   logic [12:0]  e_b_ff;
   logic         s_b_ff, z_b_ff;

   logic         hi, g, st, up;
   logic [52:0]  mant;
   logic [53:0]  m2;
   logic [12:0]  e1, e2;
   logic [51:0]  frac;
   fexp_pkg::f64_type y_in, y_ff;

   // split each significand into 26 + 27 bits
   assign ma    = {|a[62:52], a[51:0]};
   assign mb    = {|b[62:52], b[51:0]};
   assign hh_in = 52'(ma[52:27]) * 52'(mb[52:27]);
   assign hl_in = 53'(ma[52:27]) * 53'(mb[26:0]);
   assign lh_in = 53'(ma[26:0]) * 53'(mb[52:27]);
   assign ll_in = 54'(ma[26:0]) * 54'(mb[26:0]);
   assign e_in  = 13'(a[62:52]) + 13'(b[62:52]) - 13'(fexp_pkg::EXP_BIAS);

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff  <= hh_in;
         hl_ff  <= hl_in;
         lh_ff  <= lh_in;
         ll_ff  <= ll_in;
         e_a_ff <= e_in;
         s_a_ff <= a[63] ^ b[63];
         z_a_ff <= (a[62:52] == '0) || (b[62:52] == '0);
      end
   end

   assign mid  = 106'(hl_ff) + 106'(lh_ff);
   assign p_in = {hh_ff, 54'b0} + (mid << 27) + 106'(ll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         e_b_ff <= e_a_ff;
         s_b_ff <= s_a_ff;
         z_b_ff <= z_a_ff;
      end
   end

   // normalise by at most one place, then round to nearest even
   assign hi   = p_ff[105];
   assign mant = hi ? p_ff[105:53] : p_ff[104:52];
   assign g    = hi ? p_ff[52] : p_ff[51];
   assign st   = hi ? |p_ff[51:0] : |p_ff[50:0];
   assign e1   = e_b_ff + 13'(hi);
   assign up   = g & (st | mant[0]);
   assign m2   = {1'b0, mant} + 54'(up);
   assign e2   = e1 + 13'(m2[53]);
   assign frac = m2[53] ? '0 : m2[51:0];
   assign y_in = z_b_ff ? {s_b_ff, 63'b0} : {s_b_ff, e2[10:0], frac};

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

>>> rtl/fexp_add64.sv
`timescale 1ns / 1ps

module fexp_add64 (
   input  logic              clock,
   input  logic              en,
   input  fexp_pkg::f64_type a,
   input  fexp_pkg::f64_type b,
   output fexp_pkg::f64_type y
);

   logic              a_big;
   fexp_pkg::f64_type big, sml;
   logic [10:0]       diff;
   logic [5:0]        d_in;

   logic [52:0]       mb_ff, ms_ff;
   logic [5:0]        d_ff;
   logic [10:0]       e_a_ff;
   logic              s_a_ff, sub_a_ff, zs_a_ff;

   logic [108:0]      shifted;
   logic [55:0]       al;
   logic              sh_st;
   logic [56:0]       big_ext, sml_ext, sum_in;

   logic [56:0]       sum_b_ff;
   logic [10:0]       e_b_ff;
   logic              s_b_ff, zs_b_ff;

   logic [5:0]        lz_in;
   logic [56:0]       sum_c_ff;
   logic [5:0]        lz_ff;
   logic [10:0]       e_c_ff;
   logic              s_c_ff, zs_c_ff;

   logic [56:0]       norm;
   logic [52:0]       mant;
   logic              g, st, up;
   logic [53:0]       m2;
   logic [11:0]       e1, e2;
   logic [51:0]       frac;
   fexp_pkg::f64_type y_in, y_ff;

   assign a_big = a[62:0] >= b[62:0];
   assign big   = a_big ? a : b;
   assign sml   = a_big ? b : a;
   assign diff  = big[62:52] - sml[62:52];
   assign d_in  = (diff > 11'd63) ? 6'd63 : diff[5:0];

   always_ff @(posedge clock) begin
      if (en) begin
         mb_ff    <= {|big[62:52], big[51:0]};
         ms_ff    <= {|sml[62:52], sml[51:0]};
         d_ff     <= d_in;
         e_a_ff   <= big[62:52];
         s_a_ff   <= big[63];
         sub_a_ff <= a[63] ^ b[63];
         zs_a_ff  <= a[63] & b[63];
      end
   end

   // guard, round and sticky below the significand
   assign shifted = {ms_ff, 56'b0} >> d_ff;
   assign al      = shifted[108:53];
   assign sh_st   = |shifted[52:0];
   assign big_ext = {1'b0, mb_ff, 3'b000};
   assign sml_ext = {1'b0, al[55:1], al[0] | sh_st};
   assign sum_in  = sub_a_ff ? (big_ext - sml_ext) : (big_ext + sml_ext);

   always_ff @(posedge clock) begin
      if (en) begin
         sum_b_ff <= sum_in;
         e_b_ff   <= e_a_ff;
         s_b_ff   <= s_a_ff;
         zs_b_ff  <= zs_a_ff;
      end
   end

   always_comb begin
      lz_in = '0;
      for (int i = 0; i < 57; i++) begin
         if (sum_b_ff[i]) begin
            lz_in = 6'(56 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_c_ff <= sum_b_ff;
         lz_ff    <= lz_in;
         e_c_ff   <= e_b_ff;
         s_c_ff   <= s_b_ff;
         zs_c_ff  <= zs_b_ff;
      end
   end

   assign norm = sum_c_ff << lz_ff;
   assign mant = norm[56:4];
   assign g    = norm[3];
   assign st   = |norm[2:0];
   assign e1   = {1'b0, e_c_ff} + 12'd1 - {6'b0, lz_ff};
   assign up   = g & (st | mant[0]);
   assign m2   = {1'b0, mant} + 54'(up);
   assign e2   = e1 + 12'(m2[53]);
   assign frac = m2[53] ? '0 : m2[51:0];

   // exact cancellation gives +0 unless both operands were -0
   assign y_in = (sum_c_ff == '0) ? {zs_c_ff, 63'b0} : {s_c_ff, e2[10:0], frac};

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

>>> rtl/fexp_nar.sv
`timescale 1ns / 1ps

module fexp_nar (
   input  logic              clock,
   input  logic              en,
   input  fexp_pkg::f64_type d,
   output logic [31:0]       y
);

   logic               s;
   logic [52:0]        ms;
   logic signed [11:0] ef, tot;
   logic [5:0]         tot_c;
   logic [116:0]       wide;
   logic [31:0]        base_in;
   logic               g, st, inf_in;

   logic [31:0]        base_ff;
   logic               up_ff, inf_ff, s_ff;
   logic [31:0]        y_in, y_ff;

   assign s     = d[63];
   assign ms    = {|d[62:52], d[51:0]};
   assign ef    = signed'(12'(d[62:52]) - 12'(fexp_pkg::EXP_REBIAS));
   assign tot   = 12'sd30 - ef;
   assign tot_c = (tot > 12'sd63) ? 6'd63 : tot[5:0];
   assign wide  = {ms, 64'b0} >> tot_c;
   assign inf_in = ef >= 12'sd255;

   always_comb begin
      if (ef >= 12'sd1) begin
         base_in = {s, ef[7:0], d[51:29]};
         g       = d[28];
         st      = |d[27:0];
      end else begin
         // subnormal result
         base_in = {s, 8'b0, wide[86:64]};
         g       = wide[63];
         st      = |wide[62:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff <= base_in;
         up_ff   <= g & (st | base_in[0]);
         inf_ff  <= inf_in;
         s_ff    <= s;
      end
   end

   // a carry out of the fraction steps the exponent, up to infinity
   assign y_in = inf_ff ? {s_ff, fexp_pkg::F32_INF[30:0]} : base_ff + 32'(up_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

>>> rtl/float32_exp_table_poly.sv
`timescale 1ns / 1ps
// throughput: one beat per cycle unless the output stage is full; the double
//   precision multiply and add units are fully pipelined and the whole
//   pipeline advances together
// a two-entry output stage lets req_tready stay high while one result waits
// reset clears the valid bits of the pipeline and the output stage

module float32_exp_table_poly (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // exp_bits
);

   localparam int ML = fexp_pkg::MUL_LAT;
   localparam int AL = fexp_pkg::ADD_LAT;
   localparam int Z_DLY    = 2 * AL;
   localparam int R3_DLY   = ML + AL;
   localparam int R4_DLY   = 2 * ML + AL;
   localparam int T5_DLY   = 2 * ML + AL;
   localparam int SC_DLY   = 3 * ML + 5 * AL;
   localparam int PIPE_LAT = 1 + 5 * ML + 6 * AL + fexp_pkg::NAR_LAT;

   logic        en;
   logic        xs;
   logic [7:0]  xe;
   logic [22:0] xf, fn;
   logic [30:0] mag;
   logic [4:0]  lz;
   logic        is_nan, is_inf, is_zero, is_spec;
   logic [31:0] spec_val;
   fexp_pkg::f64_type xd_in, xd_ff;

   fexp_pkg::f64_type z, z_d, kd, ki, r, r3, r4, t1, t2, t3, t4, t5, t5_d, t6;
   fexp_pkg::f64_type poly, scale_in, scale, prod;
   logic [31:0] res32;
   logic [32:0] sp;
   logic        v_last, push, pop;
   logic [31:0] push_data;

   logic        out_valid_ff, skid_valid_ff;
   logic [31:0] out_data_ff, skid_data_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   assign xs  = req_tdata[31];
   assign xe  = req_tdata[30:23];
   assign xf  = req_tdata[22:0];
   assign mag = req_tdata[30:0];

   assign is_nan  = {1'b0, mag} > fexp_pkg::F32_INF;
   assign is_inf  = !xs && ({1'b0, mag} > fexp_pkg::F32_POS_MAX);
   assign is_zero = xs && ({1'b0, mag} > fexp_pkg::F32_NEG_MAX);
   assign is_spec = is_nan || is_inf || is_zero;

   always_comb begin
      priority if (is_nan) begin
         spec_val = req_tdata | fexp_pkg::F32_QUIET;
      end else if (is_inf) begin
         spec_val = fexp_pkg::F32_INF;
      end else begin
         spec_val = fexp_pkg::F32_ZERO;
      end
   end

   always_comb begin
      lz = '0;
      for (int i = 0; i < 23; i++) begin
         if (xf[i]) begin
            lz = 5'(22 - i);
         end
      end
   end

   assign fn = xf << (lz + 5'd1);

   // widen binary32 to binary64, subnormals normalised, special inputs to +0
   always_comb begin
      if (is_spec || (xe == '0 && xf == '0)) begin
         xd_in = {xs & !is_spec, 63'b0};
      end else if (xe == '0) begin
         xd_in = {xs, fexp_pkg::EXP_REBIAS - 11'(lz), fn, 29'b0};
      end else begin
         xd_in = {xs, 11'(xe) + fexp_pkg::EXP_REBIAS, xf, 29'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xd_ff <= xd_in;
      end
   end

   // range reduction: k = round(x*32/ln2), r = z - k
   fexp_mul64 u_mul_z (.clock, .en, .a(xd_ff), .b(fexp_pkg::C_LOG2E_32), .y(z));
   fexp_add64 u_add_kd (.clock, .en, .a(z), .b(fexp_pkg::C_SHIFTER), .y(kd));
   fexp_add64 u_add_ki (.clock, .en, .a(kd), .b(fexp_pkg::C_NSHIFTER), .y(ki));

   fexp_dly #(.W(64), .N(Z_DLY)) u_dly_z (
      .clock, .reset, .en, .d(z), .q(z_d)
   );

   fexp_add64 u_add_r (.clock, .en, .a(z_d), .b({~ki[63], ki[62:0]}), .y(r));

   // cubic in r
   fexp_mul64 u_mul_t1 (.clock, .en, .a(fexp_pkg::C_POLY_A), .b(r), .y(t1));
   fexp_mul64 u_mul_t5 (.clock, .en, .a(fexp_pkg::C_POLY_C), .b(r), .y(t5));
   fexp_add64 u_add_t2 (.clock, .en, .a(t1), .b(fexp_pkg::C_POLY_B), .y(t2));

   fexp_dly #(.W(64), .N(R3_DLY)) u_dly_r3 (
      .clock, .reset, .en, .d(r), .q(r3)
   );
   fexp_mul64 u_mul_t3 (.clock, .en, .a(t2), .b(r3), .y(t3));

   fexp_dly #(.W(64), .N(R4_DLY)) u_dly_r4 (
      .clock, .reset, .en, .d(r), .q(r4)
   );
   fexp_mul64 u_mul_t4 (.clock, .en, .a(t3), .b(r4), .y(t4));

   fexp_dly #(.W(64), .N(T5_DLY)) u_dly_t5 (
      .clock, .reset, .en, .d(t5), .q(t5_d)
   );
   fexp_add64 u_add_t6 (.clock, .en, .a(t4), .b(t5_d), .y(t6));
   fexp_add64 u_add_p (.clock, .en, .a(t6), .b(fexp_pkg::C_ONE), .y(poly));

   // scale bits: table entry plus k moved up into the exponent
   assign scale_in = fexp_pkg::EXP2_TBL[kd[fexp_pkg::INDEX_BITS-1:0]]
                     + (kd << fexp_pkg::SCALE_SHIFT);

   fexp_dly #(.W(64), .N(SC_DLY)) u_dly_sc (
      .clock, .reset, .en, .d(scale_in), .q(scale)
   );

   fexp_mul64 u_mul_pr (.clock, .en, .a(poly), .b(scale), .y(prod));
   fexp_nar   u_nar (.clock, .en, .d(prod), .y(res32));

   fexp_dly #(.W(33), .N(PIPE_LAT)) u_dly_sp (
      .clock, .reset, .en, .d({is_spec, spec_val}), .q(sp)
   );
   fexp_dly #(.W(1), .N(PIPE_LAT)) u_dly_v (
      .clock, .reset, .en, .d(req_tvalid), .q(v_last)
   );

   assign push      = en && v_last;
   assign push_data = sp[32] ? sp[31:0] : res32;
   assign pop       = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> rtl/fexp_chk.sv
`timescale 1ns / 1ps

module fexp_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a held result beat stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat withdrawn");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // with nothing waiting at the output the input side is open
   a_ready_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // the input side closes only after a result was refused
   a_ready_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without a refused result");

endmodule

bind float32_exp_table_poly fexp_chk u_fexp_chk (.*);

>>> test/tb_float32_exp_table_poly.sv
`timescale 1ns / 1ps

module tb_float32_exp_table_poly;

   localparam int NUM_RANDOM  = 400;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 60;

   class exp_scoreboard;
      logic [31:0] pending_exp[$];
      int          fail_count;

      function new();
         fail_count = 0;
      endfunction

      // binary32 bits widened exactly to a real, subnormals included
      function real widen_f32(logic [31:0] b);
         logic [10:0] e64;
         logic [51:0] m64;
         int          lead;
         if (b[30:23] == 8'd0 && b[22:0] == 23'd0) begin
            return $bitstoreal({b[31], 63'd0});
         end
         if (b[30:23] == 8'd0) begin
            lead = 0;
            for (int i = 0; i < 23; i++) if (b[i]) lead = i;
            e64 = 11'(lead - 149 + 1023);
            m64 = 52'(64'(b[22:0]) << (52 - lead));
         end else if (b[30:23] == 8'hff) begin
            e64 = 11'h7ff;
            m64 = {b[22:0], 29'd0};
         end else begin
            e64 = {3'd0, b[30:23]} + fexp_pkg::EXP_REBIAS;
            m64 = {b[22:0], 29'd0};
         end
         return $bitstoreal({b[31], e64, m64});
      endfunction

      // positive binary64 narrowed to binary32, nearest even
      function logic [31:0] narrow_f64(real v);
         logic [63:0] vb, sig, rem, half, q;
         int          e32, sh;
         logic        up;
         vb = $realtobits(v);
         if (vb[62:52] == 11'd0) return fexp_pkg::F32_ZERO;
         sig = {11'd0, 1'b1, vb[51:0]};
         e32 = int'(vb[62:52]) - 896;
         sh  = (e32 >= 1) ? 29 : 30 - e32;
         if (sh > 62) return fexp_pkg::F32_ZERO;
         q    = sig >> sh;
         rem  = sig & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         up   = (rem > half) || (rem == half && q[0]);
         if (e32 >= 1) return {1'b0, e32[7:0], q[22:0]} + {31'd0, up};
         return q[31:0] + {31'd0, up};
      endfunction

      function logic [31:0] exp_of(logic [31:0] xb);
         real         xf, z, kd, r, scale, poly, prod;
         logic [63:0] kbits, sbits;
         xf = widen_f32(xb);
         if (xb[30:0] >= fexp_pkg::F32_LIMIT[30:0]) begin
            if (xb[30:0] > fexp_pkg::F32_INF[30:0]) return xb | fexp_pkg::F32_QUIET;
            if (xf > widen_f32(fexp_pkg::F32_POS_MAX)) return fexp_pkg::F32_INF;
            if (xf < -widen_f32(fexp_pkg::F32_NEG_MAX)) return fexp_pkg::F32_ZERO;
         end
         z     = $bitstoreal(fexp_pkg::C_LOG2E_32) * xf;
         kd    = z + $bitstoreal(fexp_pkg::C_SHIFTER);
         kbits = $realtobits(kd);
         kd    = kd - $bitstoreal(fexp_pkg::C_SHIFTER);
         r     = z - kd;
         sbits = fexp_pkg::EXP2_TBL[kbits[fexp_pkg::INDEX_BITS-1:0]]
                 + (kbits << fexp_pkg::SCALE_SHIFT);
         scale = $bitstoreal(sbits);
         poly  = ((($bitstoreal(fexp_pkg::C_POLY_A) * r
                    + $bitstoreal(fexp_pkg::C_POLY_B)) * r) * r
                  + $bitstoreal(fexp_pkg::C_POLY_C) * r) + 1.0;
         prod  = poly * scale;
         if (prod >= $bitstoreal(64'h47efffffF0000000)) return fexp_pkg::F32_INF;
         if (prod > $bitstoreal(64'h47efffffe0000000)) return 32'h7f7fffff;
         return narrow_f64(prod);
      endfunction

      function void note_input(logic [31:0] xb);
         pending_exp.push_back(exp_of(xb));
      endfunction

      function void check_result(logic [31:0] got);
         logic [31:0] want;
         if (pending_exp.size() == 0) begin
            $error("exp_bits: result with nothing pending, actual %h", got);
            fail_count++;
            return;
         end
         want = pending_exp.pop_front();
         if (got !== want) begin
            $error("exp_bits: expected %h actual %h", want, got);
            fail_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;   // x_bits
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // exp_bits

   exp_scoreboard sb = new();
   bit            gaps_on = 1'b1;
   int            stall_left = 0;
   int            cycle_count = 0;

   float32_exp_table_poly u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_float32_exp_table_poly: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_input(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // receiver: fresh stall drawn after every result beat
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 1;
      end else if (rsp_tvalid && rsp_tready) begin
         stall = gaps_on ? $urandom_range(0, 16) : 0;
         rsp_tready <= (stall == 0);
         stall_left <= stall;
      end else if (stall_left > 0) begin
         rsp_tready <= (stall_left == 1);
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_x(logic [31:0] xb);
      int gap;
      gap = gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= xb;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] random_x();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65)          // ordinary range, every magnitude to past the limits
         return {1'($urandom), 8'($urandom_range(96, 133)), 23'($urandom)};
      if (pick < 80)          // around the overflow and underflow edges
         return {1'($urandom), 8'($urandom_range(133, 133)), 7'($urandom_range(40, 90)),
                 16'($urandom)};
      if (pick < 88)          // tiny and subnormal arguments
         return {1'($urandom), 8'($urandom_range(0, 95)), 23'($urandom)};
      return $urandom;
   endfunction

   logic [31:0] directed_x[] = '{
      32'h00000000, 32'h80000000, 32'h3f800000, 32'hbf800000,
      32'h7f800001, 32'hffc00000, 32'h7fffffff, 32'h7f800000, 32'hff800000,
      32'h42b17217, 32'h42b17218, 32'hc2cff1b4, 32'hc2cff1b5,
      32'h42b00000, 32'hc2b00000, 32'h00000001, 32'h807fffff,
      32'h7f7fffff, 32'hff7fffff, 32'hc2c80000, 32'hc2ba0000,
      32'h42b17000, 32'h3d000000, 32'hc1a00000, 32'h40490fdb
   };

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_x[i]) send_x(directed_x[i]);
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 60 == 0) gaps_on <= (n % 120 != 0);
         send_x(random_x());
      end
      req_tvalid <= 1'b0;
      gaps_on    <= 1'b1;
      // let the monitor log the last beat before looking at the queue
      @(posedge clock);
      while (sb.pending_exp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("tb_float32_exp_table_poly: PASS");
      end else begin
         $display("tb_float32_exp_table_poly: FAIL");
      end
      $finish;
   end

endmodule
